### src/gsa_pkg.sv
package gsa_pkg;

    // Pool geometry
    localparam int SLOTS     = 1024;
    localparam int GEN_WIDTH = 16;

    // Derived widths
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int COUNT_W = $clog2(SLOTS + 1);
    localparam int HGEN_W  = 16;
    localparam int ENTRY_W = GEN_WIDTH + 1;

    typedef enum logic [1:0] {
        OP_CREATE  = 2'd0,
        OP_DESTROY = 2'd1,
        OP_CHECK   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_GEN,
        S_EXEC
    } state_t;

endpackage

### src/gsa_ram.sv
module gsa_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### src/generational_slot_allocator.sv
// Channel  | Handshake               | Payload
// ---------+-------------------------+--------------------------------------------
// input    | in_valid / in_stall     | op, slot_index, handle_gen
// output   | out_valid / out_stall   | status, out_slot, out_gen, live_count
//
// Each item passes through accept, free stack read, generation table read,
// then the update and result. The two registered memory reads lie in series,
// and one item is in flight at a time.
// Reset clears the counters and the control state; memory contents are only
// read after they have been written, so no clearing pass is run.
// The next item is accepted while a result waits on a stalled output; the
// update step holds until the output register is free.
module generational_slot_allocator
    import gsa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [SLOT_W-1:0]  slot_index,
    input  logic [HGEN_W-1:0]  handle_gen,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [SLOT_W-1:0]  out_slot,
    output logic [HGEN_W-1:0]  out_gen,
    output logic [COUNT_W-1:0] live_count
);

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  free_top_reg, free_top_next;
    logic [COUNT_W-1:0]  high_water_reg, high_water_next;
    logic [COUNT_W-1:0]  live_total_reg, live_total_next;
    logic [1:0]          op_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [HGEN_W-1:0]   hgen_reg;
    logic [SLOT_W-1:0]   gen_addr_reg, gen_addr_next;
    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [HGEN_W-1:0]   out_gen_reg, out_gen_next;

    logic                gen_we;
    logic [SLOT_W-1:0]   gen_waddr;
    logic [ENTRY_W-1:0]  gen_wdata;
    logic [SLOT_W-1:0]   gen_raddr;
    logic [ENTRY_W-1:0]  gen_rdata;
    logic                fs_we;
    logic [COUNT_W-1:0]  top_minus_one;
    logic [SLOT_W-1:0]   fs_raddr;
    logic [SLOT_W-1:0]   fs_rdata;

    logic                accept;
    logic                pop_avail;
    logic                fresh_avail;
    logic                handle_ok;
    logic                exec_fire;

    // Generation table: {live, generation} per slot
    gsa_ram #(
        .DEPTH (SLOTS),
        .WIDTH (ENTRY_W)
    ) u_gen_ram (
        .clk     (clk),
        .wr_en   (gen_we),
        .wr_addr (gen_waddr),
        .wr_data (gen_wdata),
        .rd_addr (gen_raddr),
        .rd_data (gen_rdata)
    );

    // Free stack of recycled slots
    gsa_ram #(
        .DEPTH (SLOTS),
        .WIDTH (SLOT_W)
    ) u_free_ram (
        .clk     (clk),
        .wr_en   (fs_we),
        .wr_addr (free_top_reg[SLOT_W-1:0]),
        .wr_data (slot_reg),
        .rd_addr (fs_raddr),
        .rd_data (fs_rdata)
    );

    assign accept        = in_valid && !in_stall;
    assign in_stall      = (state_reg != S_IDLE);
    assign top_minus_one = free_top_reg - COUNT_W'(1);
    assign fs_raddr      = top_minus_one[SLOT_W-1:0];
    assign pop_avail     = (free_top_reg != '0);
    assign fresh_avail   = (high_water_reg < COUNT_W'(SLOTS));
    assign exec_fire     = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    // Address the table with the popped slot for a recycle, else the handle slot
    always_comb
    begin
        gen_addr_next = gen_addr_reg;
        if (state_reg == S_GEN)
        begin
            if (op_t'(op_reg) == OP_CREATE && pop_avail)
            begin
                gen_addr_next = fs_rdata;
            end
            else
            begin
                gen_addr_next = slot_reg;
            end
        end
    end

    assign gen_raddr = (state_reg == S_GEN) ? gen_addr_next : gen_addr_reg;

    // Handle is valid if its slot was used, is live, and the generation matches
    assign handle_ok = ({1'b0, slot_reg} < high_water_reg) && gen_rdata[GEN_WIDTH]
                       && (HGEN_W'(gen_rdata[GEN_WIDTH-1:0]) == hgen_reg);

    // Sequence the item and apply the update
    always_comb
    begin
        state_next      = state_reg;
        free_top_next   = free_top_reg;
        high_water_next = high_water_reg;
        live_total_next = live_total_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        out_slot_next   = out_slot_reg;
        out_gen_next    = out_gen_reg;
        gen_we          = 1'b0;
        gen_waddr       = gen_addr_reg;
        gen_wdata       = '0;
        fs_we           = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                state_next = S_GEN;
            end
            S_GEN:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = ST_INVALID;
                    out_slot_next  = slot_reg;
                    out_gen_next   = hgen_reg;
                    case (op_t'(op_reg))
                        OP_CREATE:
                        begin
                            if (pop_avail)
                            begin
                                free_top_next   = top_minus_one;
                                live_total_next = live_total_reg + COUNT_W'(1);
                                gen_we          = 1'b1;
                                gen_wdata       = {1'b1, gen_rdata[GEN_WIDTH-1:0]};
                                out_slot_next   = gen_addr_reg;
                                out_gen_next    = HGEN_W'(gen_rdata[GEN_WIDTH-1:0]);
                                status_next     = ST_OK;
                            end
                            else if (fresh_avail)
                            begin
                                high_water_next = high_water_reg + COUNT_W'(1);
                                live_total_next = live_total_reg + COUNT_W'(1);
                                gen_we          = 1'b1;
                                gen_waddr       = high_water_reg[SLOT_W-1:0];
                                gen_wdata       = {1'b1, {GEN_WIDTH{1'b0}}};
                                out_slot_next   = high_water_reg[SLOT_W-1:0];
                                out_gen_next    = '0;
                                status_next     = ST_OK;
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                        OP_DESTROY:
                        begin
                            if (handle_ok && free_top_reg < COUNT_W'(SLOTS))
                            begin
                                gen_we        = 1'b1;
                                gen_wdata     = {1'b0, gen_rdata[GEN_WIDTH-1:0]
                                                       + GEN_WIDTH'(1)};
                                fs_we         = 1'b1;
                                free_top_next = free_top_reg + COUNT_W'(1);
                                if (live_total_reg != '0)
                                begin
                                    live_total_next = live_total_reg - COUNT_W'(1);
                                end
                                status_next = ST_OK;
                            end
                        end
                        OP_CHECK:
                        begin
                            status_next = handle_ok ? ST_OK : ST_INVALID;
                        end
                        default:
                        begin
                            status_next = ST_INVALID;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_top_reg   <= '0;
            high_water_reg <= '0;
            live_total_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_top_reg   <= free_top_next;
            high_water_reg <= high_water_next;
            live_total_reg <= live_total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold the item and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op;
            slot_reg <= slot_index;
            hgen_reg <= handle_gen;
        end
        gen_addr_reg <= gen_addr_next;
        status_reg   <= status_next;
        out_slot_reg <= out_slot_next;
        out_gen_reg  <= out_gen_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign out_slot   = out_slot_reg;
    assign out_gen    = out_gen_reg;
    assign live_count = live_total_reg;

endmodule

### src/gsa_checker.sv
module gsa_checker
    import gsa_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [1:0]         op,
    input logic [SLOT_W-1:0]  slot_index,
    input logic [HGEN_W-1:0]  handle_gen,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         status,
    input logic [SLOT_W-1:0]  out_slot,
    input logic [HGEN_W-1:0]  out_gen,
    input logic [COUNT_W-1:0] live_count
);

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_slot)
                                   && $stable(out_gen) && $stable(live_count))
    else $error("stalled result changed");

    // Status never carries the unused code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
    else $error("unused status code");

    // Busy after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("item accepted while previous one still in work");

    // Full pool means every slot is live
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> live_count == COUNT_W'(SLOTS))
    else $error("full reported with free slots");

    // Live count never exceeds the pool
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> live_count <= COUNT_W'(SLOTS))
    else $error("live count beyond pool size");

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (.*);

### dv/generational_slot_allocator_tb.sv
module generational_slot_allocator_tb;
    import gsa_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam longint unsigned GEN_MASK = (64'd1 << GEN_WIDTH) - 64'd1;
    localparam int RANDOM_REQS = 560;
    localparam int HOLD_AT_RESULT = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [HGEN_W-1:0]  gen;
        logic [COUNT_W-1:0] live;
    } alloc_result_t;

    typedef struct {
        logic [1:0]        op;
        logic [SLOT_W-1:0] slot;
        logic [HGEN_W-1:0] gen;
        alloc_result_t     want;
    } alloc_req_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         op = '0;
    logic [SLOT_W-1:0]  slot_index = '0;
    logic [HGEN_W-1:0]  handle_gen = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic [SLOT_W-1:0]  out_slot;
    logic [HGEN_W-1:0]  out_gen;
    logic [COUNT_W-1:0] live_count;

    // Shadow allocator state
    logic [HGEN_W-1:0] pool_gen [SLOTS];
    logic [SLOT_W-1:0] pool_free [SLOTS];
    bit                pool_live [SLOTS];
    int                pool_free_top = 0;
    int                pool_high_water = 0;
    int                pool_live_total = 0;
    int                live_slots[$];

    alloc_req_t    pending_reqs[$];
    alloc_result_t pending_results[$];
    alloc_req_t    cur_req;
    alloc_result_t got_want;
    int            total_reqs = 0;
    int            sent_count = 0;
    int            recv_count = 0;
    int            err_count = 0;
    int            send_gap = 0;
    int            send_calm = 0;
    int            recv_gap = 0;
    int            recv_calm = 0;
    int            hold_left = 0;
    int            idle_cycles = 0;

    generational_slot_allocator u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .slot_index (slot_index),
        .handle_gen (handle_gen),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .out_slot   (out_slot),
        .out_gen    (out_gen),
        .live_count (live_count)
    );

    always #6 clk = ~clk;

    // A handle is valid when its slot was handed out, is live, and holds that generation
    function automatic bit handle_valid(logic [SLOT_W-1:0] slot_in, logic [HGEN_W-1:0] gen_in);
        if (int'(slot_in) >= pool_high_water)
            return 1'b0;
        if (!pool_live[slot_in])
            return 1'b0;
        return 64'(gen_in) == 64'(pool_gen[slot_in]);
    endfunction

    // Apply one request to the shadow pool and return its result
    function automatic alloc_result_t predict_alloc(logic [1:0] op_in,
                                                    logic [SLOT_W-1:0] slot_in,
                                                    logic [HGEN_W-1:0] gen_in);
        alloc_result_t r;
        int s;
        r.status = ST_INVALID;
        r.slot = slot_in;
        r.gen = gen_in;
        case (op_in)
            OP_CREATE:
            begin
                if (pool_free_top > 0)
                begin
                    pool_free_top--;
                    s = int'(pool_free[pool_free_top]);
                    pool_live[s] = 1'b1;
                    pool_live_total++;
                    r.slot = SLOT_W'(s);
                    r.gen = pool_gen[s];
                    r.status = ST_OK;
                end
                else if (pool_high_water < SLOTS)
                begin
                    s = pool_high_water;
                    pool_gen[s] = '0;
                    pool_live[s] = 1'b1;
                    pool_high_water++;
                    pool_live_total++;
                    r.slot = SLOT_W'(s);
                    r.gen = '0;
                    r.status = ST_OK;
                end
                else
                begin
                    r.status = ST_FULL;
                end
            end
            OP_DESTROY:
            begin
                if (handle_valid(slot_in, gen_in) && pool_free_top < SLOTS)
                begin
                    pool_gen[slot_in] = HGEN_W'((64'(pool_gen[slot_in]) + 64'd1) & GEN_MASK);
                    pool_live[slot_in] = 1'b0;
                    pool_free[pool_free_top] = slot_in;
                    pool_free_top++;
                    if (pool_live_total > 0)
                        pool_live_total--;
                    r.status = ST_OK;
                end
            end
            OP_CHECK:
            begin
                r.status = handle_valid(slot_in, gen_in) ? ST_OK : ST_INVALID;
            end
            default:
            begin
            end
        endcase
        r.live = COUNT_W'(pool_live_total);
        return r;
    endfunction

    // Predict a request, track live handles, and queue it for the driver
    task automatic queue_req(logic [1:0] op_in, int slot_in, int gen_in);
        alloc_req_t req;
        req.op = op_in;
        req.slot = SLOT_W'(slot_in);
        req.gen = HGEN_W'(gen_in);
        req.want = predict_alloc(req.op, req.slot, req.gen);
        if (req.op == OP_CREATE && req.want.status == ST_OK)
            live_slots.insert(live_slots.size(), int'(req.want.slot));
        if (req.op == OP_DESTROY && req.want.status == ST_OK)
        begin
            for (int i = 0; i < live_slots.size(); i++)
            begin
                if (live_slots[i] == int'(req.slot))
                begin
                    live_slots.delete(i);
                    break;
                end
            end
        end
        pending_reqs.insert(pending_reqs.size(), req);
        total_reqs++;
    endtask

    function automatic int rand_live_slot();
        return live_slots[$urandom_range(0, live_slots.size() - 1)];
    endfunction

    task automatic queue_noise();
        queue_req(2'($urandom_range(0, 3)), $urandom_range(0, SLOTS - 1), $urandom_range(0, 65535));
    endtask

    task automatic queue_create();
        queue_req(OP_CREATE, $urandom_range(0, SLOTS - 1), $urandom_range(0, 65535));
    endtask

    task automatic queue_live(logic [1:0] op_in);
        int s;
        if (live_slots.size() == 0)
        begin
            queue_create();
        end
        else
        begin
            s = rand_live_slot();
            queue_req(op_in, s, int'(pool_gen[s]));
        end
    endtask

    task automatic check_field(string name, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
            err_count++;
        end
    endtask

    // Driver: present queued items, draw an idle gap after each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                pending_results.insert(pending_results.size(), cur_req.want);
                sent_count++;
                if (send_calm > 0)
                begin
                    send_calm--;
                    send_gap = 0;
                end
                else if ($urandom_range(0, 19) == 0)
                begin
                    send_calm = $urandom_range(10, 40);
                    send_gap = 0;
                end
                else
                begin
                    send_gap = $urandom_range(0, 8);
                end
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    op <= cur_req.op;
                    slot_index <= cur_req.slot;
                    handle_gen <= cur_req.gen;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest prediction and drive stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual status %0d slot %0d",
                             $time, status, out_slot);
                    err_count++;
                end
                else
                begin
                    got_want = pending_results.pop_front();
                    check_field("status", int'(got_want.status), int'(status));
                    check_field("out_slot", int'(got_want.slot), int'(out_slot));
                    check_field("out_gen", int'(got_want.gen), int'(out_gen));
                    check_field("live_count", int'(got_want.live), int'(live_count));
                end
                recv_count++;
                // Hold off once for a long stretch so the block backs up
                if (recv_count == HOLD_AT_RESULT)
                    hold_left = HOLD_CYCLES;
                if (recv_calm > 0)
                begin
                    recv_calm--;
                    recv_gap = 0;
                end
                else if ($urandom_range(0, 19) == 0)
                begin
                    recv_calm = $urandom_range(10, 40);
                    recv_gap = 0;
                end
                else
                begin
                    recv_gap = $urandom_range(0, 8);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run when no item moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int pick;
        int s;

        // Directed: empty pool, recycling order, stale and freed handles, unused op
        queue_req(OP_CHECK, 0, 0);
        queue_req(OP_DESTROY, SLOTS - 1, 16'hFFFF);
        queue_req(OP_CREATE, SLOTS - 1, 16'hFFFF);
        queue_req(OP_CREATE, 0, 0);
        queue_req(OP_CHECK, 0, 0);
        queue_req(OP_CHECK, 0, 16'hFFFF);
        queue_req(OP_DESTROY, 0, 0);
        queue_req(OP_CHECK, 0, 0);
        queue_req(OP_CHECK, 0, 1);
        queue_req(OP_DESTROY, 0, 1);
        queue_req(OP_CREATE, 0, 0);
        queue_req(OP_CHECK, 0, 1);
        queue_req(OP_DESTROY, 1, 0);
        queue_req(OP_DESTROY, 0, 1);
        queue_req(OP_CREATE, 0, 0);
        queue_req(OP_CREATE, 0, 0);
        queue_req(OP_CHECK, 1, 1);
        queue_req(OP_CHECK, 2, 0);
        queue_req(OP_CHECK, SLOTS - 1, 16'hFFFF);
        queue_req(OP_UNUSED, SLOTS - 1, 16'hFFFF);
        queue_req(OP_UNUSED, 0, 0);

        // Random: mostly well-formed handles, plus stale, freed, unused and noise
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                queue_create();
            end
            else if (pick < 55)
            begin
                queue_live(OP_DESTROY);
            end
            else if (pick < 68)
            begin
                queue_live(OP_CHECK);
            end
            else if (pick < 76 && live_slots.size() > 0)
            begin
                s = rand_live_slot();
                queue_req(2'($urandom_range(1, 2)), s,
                          int'(pool_gen[s]) + $urandom_range(1, 65535));
            end
            else if (pick < 82 && pool_free_top > 0)
            begin
                s = int'(pool_free[$urandom_range(0, pool_free_top - 1)]);
                queue_req(2'($urandom_range(1, 2)), s,
                          int'(pool_gen[s]) - $urandom_range(0, 1));
            end
            else if (pick < 88 && pool_high_water < SLOTS)
            begin
                queue_req(2'($urandom_range(1, 2)), $urandom_range(pool_high_water, SLOTS - 1),
                          $urandom_range(0, 65535));
            end
            else if (pick < 92)
            begin
                queue_req(OP_UNUSED, $urandom_range(0, SLOTS - 1), $urandom_range(0, 65535));
            end
            else
            begin
                queue_noise();
            end
        end

        // Recycle a batch, then drain part of the pool
        repeat (3) queue_create();
        queue_live(OP_CHECK);
        repeat (5) queue_live(OP_DESTROY);
        repeat (6) queue_create();
        repeat (150)
        begin
            if ($urandom_range(0, 3) == 0)
                queue_live(OP_CHECK);
            else
                queue_live(OP_DESTROY);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (sent_count == total_reqs && pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
